FILE: sv/kvl_pkg.sv
// Shared types and constants for the keyframe vector interpolation block.
// No dependencies; used by keyframe_vector_lerp and its testbench.
`default_nettype none

package kvl_pkg;

  // Keyframe table geometry.
  localparam int unsigned MAX_KEYS = 64;
  localparam int unsigned KeyIdxW  = $clog2(MAX_KEYS);

  // Field widths.
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CompW   = 32;
  localparam int unsigned CountW  = 7;
  localparam int unsigned FracW   = 16;
  localparam int unsigned NumComp = 3;

  // Stream payload widths.
  localparam int unsigned InDataW  = 136;
  localparam int unsigned OutDataW = 96;

  // One table row: time in the low bits, then x, y and z.
  localparam int unsigned RowW = TimeW + NumComp * CompW;

  // Request kinds carried in tuser.
  localparam logic ACT_QUERY = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SEG_RD,
    ST_START,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } kvl_state_e;

endpackage

`default_nettype wire

FILE: sv/keyframe_vector_lerp.sv
// Keyframe table with linear interpolation of a 3-component vector.
// Depends on kvl_pkg for constants and the sequencer state type.
// Operation: a write request is stored in the table as it is accepted. A query runs a
// serial segment search over the keys scanned (one table read and one compare each),
// then the bit-serial fraction divider when the time falls strictly inside a segment,
// then a multiply and an add per component. With one key only, the search is skipped.
// Throughput: one query at a time; a finished result waits in the output register.
// Reset: asynchronous, active low; key_count returns to 1, the table is not cleared.
`default_nettype none

module keyframe_vector_lerp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Slave stream.
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  // tdata: key_slot[5:0], time_value[37:6], comp_x[69:38], comp_y[101:70],
  //        comp_z[133:102], zero fill [135:134].
  input  wire logic [kvl_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: action[0].
  input  wire logic                          s_axis_tuser,
  // Master stream.
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // tdata: out_x[31:0], out_y[63:32], out_z[95:64].
  output      logic [kvl_pkg::OutDataW-1:0]  m_axis_tdata,
  // Key count register.
  input  wire logic                          cfg_we_i,
  input  wire logic [kvl_pkg::CountW-1:0]    cfg_wdata_i
);

  import kvl_pkg::*;

  // Sequencer state and control.
  kvl_state_e            state_q, state_d;
  logic [CountW-1:0]     key_count_q;
  logic [KeyIdxW-1:0]    cnt_q;
  logic [KeyIdxW-1:0]    last_idx_q;
  logic                  single_q;
  logic [3:0]            div_cnt_q;
  logic [1:0]            comp_q;
  logic                  out_vld_q;

  // Datapath registers.
  logic [TimeW-1:0]      tm_q;
  logic [TimeW-1:0]      end_t_q;
  logic [CompW-1:0]      start_vec_q [NumComp];
  logic [CompW-1:0]      end_vec_q   [NumComp];
  logic [CompW-1:0]      res_q       [NumComp];
  logic [CompW-1:0]      out_q       [NumComp];
  logic [TimeW-1:0]      rem_q;
  logic [TimeW-1:0]      dvs_q;
  logic [FracW:0]        t_q;
  logic signed [CompW+FracW+2:0] prod_q;

  // Table memory and its registered read port.
  logic [RowW-1:0]       mem_q [MAX_KEYS];
  logic [RowW-1:0]       rdata_q;
  logic [KeyIdxW-1:0]    rd_addr;

  // Request decode.
  logic                  in_acc;
  logic                  in_write;
  logic                  in_query;
  logic [KeyIdxW-1:0]    in_slot;
  logic [TimeW-1:0]      in_time;
  logic [RowW-1:0]       in_row;

  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign in_write = in_acc & (s_axis_tuser == ACT_WRITE);
  assign in_query = in_acc & (s_axis_tuser == ACT_QUERY);
  assign in_slot  = s_axis_tdata[KeyIdxW-1:0];
  assign in_time  = s_axis_tdata[KeyIdxW +: TimeW];
  assign in_row   = {s_axis_tdata[KeyIdxW+TimeW +: NumComp*CompW], in_time};

  // Effective key count: zero counts as one, large values saturate.
  logic [CountW-1:0]     n_eff;
  logic [CountW-1:0]     n_last;

  always_comb begin
    if (key_count_q == '0) begin
      n_eff = CountW'(1);
    end else if (key_count_q > CountW'(MAX_KEYS)) begin
      n_eff = CountW'(MAX_KEYS);
    end else begin
      n_eff = key_count_q;
    end
    n_last = n_eff - CountW'(1);
  end

  // Fields of the row just read.
  logic [TimeW-1:0]      rd_time;
  assign rd_time = rdata_q[TimeW-1:0];

  // Segment search compare: stop at the first later key, or at the last key.
  logic                  srch_hit;
  assign srch_hit = (tm_q < rd_time) || (cnt_q == last_idx_q);

  // One step of the restoring divider.
  logic [TimeW:0]        rem_sh;
  logic                  q_bit;
  logic [TimeW:0]        rem_sub;

  always_comb begin
    rem_sh  = {rem_q, 1'b0};
    q_bit   = rem_sh >= {1'b0, dvs_q};
    rem_sub = rem_sh - {1'b0, dvs_q};
  end

  // Shared multiplier: (end - start) * t for the selected component.
  logic [CompW-1:0]          sel_start;
  logic [CompW-1:0]          sel_end;
  logic signed [CompW:0]     diff;
  logic signed [CompW+FracW+2:0] prod_d;

  always_comb begin
    case (comp_q)
      2'd0:    begin sel_start = start_vec_q[0]; sel_end = end_vec_q[0]; end
      2'd1:    begin sel_start = start_vec_q[1]; sel_end = end_vec_q[1]; end
      default: begin sel_start = start_vec_q[2]; sel_end = end_vec_q[2]; end
    endcase
    diff   = $signed({sel_end[CompW-1], sel_end}) - $signed({sel_start[CompW-1], sel_start});
    prod_d = diff * $signed({1'b0, t_q});
  end

  // Result of one component: start plus the floored, scaled product.
  logic [CompW-1:0]      comp_sum;
  assign comp_sum = sel_start + prod_q[FracW +: CompW];

  // Output register may take a new result when empty or being drained.
  logic                  out_free;
  assign out_free = !out_vld_q || m_axis_tready;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_query) begin
          state_d = (n_eff == CountW'(1)) ? ST_START : ST_SRCH_RD;
        end
      end
      ST_SRCH_RD:  state_d = ST_SRCH_CMP;
      ST_SRCH_CMP: state_d = srch_hit ? ST_SEG_RD : ST_SRCH_RD;
      ST_SEG_RD:   state_d = ST_START;
      ST_START: begin
        if (single_q || (tm_q <= rd_time) || (tm_q >= end_t_q)) begin
          state_d = ST_MUL;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV:      state_d = (div_cnt_q == 4'd15) ? ST_MUL : ST_DIV;
      ST_MUL:      state_d = ST_ADD;
      ST_ADD:      state_d = (comp_q == 2'd2) ? ST_DONE : ST_MUL;
      ST_DONE:     state_d = out_free ? ST_IDLE : ST_DONE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and table read address.
  always_comb begin
    s_axis_tready = 1'b0;
    rd_addr       = '0;
    unique case (state_q)
      ST_IDLE:     s_axis_tready = 1'b1;
      ST_SRCH_RD:  rd_addr = cnt_q;
      ST_SEG_RD:   rd_addr = cnt_q - KeyIdxW'(1);
      default:     rd_addr = '0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      key_count_q <= CountW'(1);
      cnt_q       <= '0;
      last_idx_q  <= '0;
      single_q    <= 1'b0;
      div_cnt_q   <= '0;
      comp_q      <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        key_count_q <= cfg_wdata_i;
      end
      if (in_query) begin
        cnt_q      <= KeyIdxW'(1);
        last_idx_q <= n_last[KeyIdxW-1:0];
        single_q   <= (n_eff == CountW'(1));
        comp_q     <= '0;
        div_cnt_q  <= '0;
      end
      if (state_q == ST_SRCH_CMP && !srch_hit) begin
        cnt_q <= cnt_q + KeyIdxW'(1);
      end
      if (state_q == ST_DIV) begin
        div_cnt_q <= div_cnt_q + 4'd1;
      end
      if (state_q == ST_ADD) begin
        comp_q <= comp_q + 2'd1;
      end
      if (state_q == ST_DONE && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Keyframe table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (in_write) begin
      mem_q[in_slot] <= in_row;
    end
    rdata_q <= mem_q[rd_addr];
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_query) begin
      tm_q <= in_time;
    end
    // The last row compared is always the segment's end key.
    if (state_q == ST_SRCH_CMP) begin
      end_t_q <= rd_time;
      for (int c = 0; c < NumComp; c++) begin
        end_vec_q[c] <= rdata_q[TimeW + c*CompW +: CompW];
      end
    end
    // Latch the start key and pick the clamped or divided fraction.
    if (state_q == ST_START) begin
      for (int c = 0; c < NumComp; c++) begin
        start_vec_q[c] <= rdata_q[TimeW + c*CompW +: CompW];
      end
      // A lone key is also its own end point, so the span is zero.
      if (single_q) begin
        for (int c = 0; c < NumComp; c++) begin
          end_vec_q[c] <= rdata_q[TimeW + c*CompW +: CompW];
        end
      end
      rem_q <= tm_q - rd_time;
      dvs_q <= end_t_q - rd_time;
      if (single_q || (tm_q <= rd_time)) begin
        t_q <= '0;
      end else if (tm_q >= end_t_q) begin
        t_q <= {1'b1, {FracW{1'b0}}};
      end else begin
        t_q <= '0;
      end
    end
    // One quotient bit per cycle.
    if (state_q == ST_DIV) begin
      rem_q <= q_bit ? rem_sub[TimeW-1:0] : rem_sh[TimeW-1:0];
      t_q   <= {1'b0, t_q[FracW-2:0], q_bit};
    end
    if (state_q == ST_MUL) begin
      prod_q <= prod_d;
    end
    if (state_q == ST_ADD) begin
      res_q[comp_q] <= comp_sum;
    end
    if (state_q == ST_DONE && out_free) begin
      out_q <= res_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q[2], out_q[1], out_q[0]};

  // The partial remainder stays below the divisor throughout the division.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < dvs_q))
    else $error("divider remainder not below divisor");

  // The fraction never exceeds one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    t_q[FracW] |-> (t_q[FracW-1:0] == '0))
    else $error("fraction above one");

  // The search never walks past the last valid key.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SRCH_RD) || (state_q == ST_SRCH_CMP)) |-> (cnt_q <= last_idx_q))
    else $error("segment search out of range");

  // A result handed over from the sequencer shows on the output next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && out_free) |=> (m_axis_tvalid && (state_q == ST_IDLE)))
    else $error("result not presented");

  // Input is refused right after a query that searches more than one key is accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_query && (n_eff != CountW'(1))) |=> !s_axis_tready)
    else $error("request accepted during query");

endmodule

`default_nettype wire

FILE: dv/tb_keyframe_vector_lerp.sv
// Self-checking testbench for keyframe_vector_lerp: key loads and interpolation
// queries, predicted by an in-bench fixed-point interpolator and checked per result.
// Depends on kvl_pkg and the keyframe_vector_lerp RTL.
module tb_keyframe_vector_lerp;
  import kvl_pkg::*;

  localparam int unsigned ClkHalf     = 10;
  localparam int unsigned CycleLimit  = 1_200_000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned TailCycles  = 200;
  localparam int unsigned RandomItems = 1300;
  localparam int unsigned TailItems   = 150;
  localparam logic [FracW:0] FracOne  = {1'b1, {FracW{1'b0}}};

  // Interpolated vector, x in the lowest bits as on the master stream.
  typedef struct packed {
    logic [CompW-1:0] z;
    logic [CompW-1:0] y;
    logic [CompW-1:0] x;
  } vec_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [InDataW-1:0]     s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OutDataW-1:0]    m_axis_tdata;
  logic                   cfg_we_i      = 1'b0;
  logic [CountW-1:0]      cfg_wdata_i   = '0;

  // Shadow copy of the key table and the key count register.
  logic [TimeW-1:0]        shadow_time [MAX_KEYS];
  logic signed [CompW-1:0] shadow_x    [MAX_KEYS];
  logic signed [CompW-1:0] shadow_y    [MAX_KEYS];
  logic signed [CompW-1:0] shadow_z    [MAX_KEYS];
  logic [CountW-1:0]       shadow_count = 7'd1;

  vec_t        pending_vecs[$];
  vec_t        rx_vec;
  vec_t        want_vec;
  int unsigned items_sent   = 0;
  int unsigned queries_sent = 0;
  int unsigned writes_sent  = 0;
  int unsigned results_seen = 0;
  int unsigned err_count    = 0;
  int unsigned cycle_count  = 0;
  int unsigned stall_left   = 0;
  bit          send_idle_en = 1'b1;
  bit          sink_idle_en = 1'b1;

  keyframe_vector_lerp u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Clock with a 20 unit period.
  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  // Cycle counter and watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("%0t: timeout, %0d results still pending", $time, pending_vecs.size());
    $display("keyframe_vector_lerp verification failed");
    $finish;
  end

  // Number of keys the block actually uses: zero counts as one, large values saturate.
  function automatic int unsigned used_keys();
    int unsigned n;
    n = shadow_count;
    if (n < 1) n = 1;
    if (n > MAX_KEYS) n = MAX_KEYS;
    return n;
  endfunction

  // One component: start plus the floored product of the span and the fraction.
  function automatic logic [CompW-1:0] blend(input logic signed [CompW-1:0] a,
                                             input logic signed [CompW-1:0] b,
                                             input logic [FracW:0] frac);
    longint span;
    longint prod;
    span = longint'(b) - longint'(a);
    prod = span * longint'(frac);
    return CompW'(longint'(a) + (prod >>> FracW));
  endfunction

  // Expected vector for a query at animation time tm.
  function automatic vec_t lerp_at_time(input logic [TimeW-1:0] tm);
    int unsigned n;
    int unsigned seg;
    logic [TimeW-1:0] t0;
    logic [TimeW-1:0] t1;
    logic [TimeW+FracW-1:0] num;
    logic [FracW:0] frac;
    vec_t r;
    n = used_keys();
    if (n == 1) begin
      r.x = shadow_x[0];
      r.y = shadow_y[0];
      r.z = shadow_z[0];
      return r;
    end
    // First segment whose end key lies later; otherwise the final segment.
    seg = n - 2;
    for (int unsigned i = 0; i + 1 < n; i++) begin
      if (tm < shadow_time[i+1]) begin
        seg = i;
        break;
      end
    end
    t0 = shadow_time[seg];
    t1 = shadow_time[seg+1];
    if (tm <= t0) begin
      frac = '0;
    end else if (tm >= t1) begin
      frac = FracOne;
    end else begin
      num  = {tm - t0, {FracW{1'b0}}};
      frac = (FracW+1)'(num / (t1 - t0));
    end
    r.x = blend(shadow_x[seg], shadow_x[seg+1], frac);
    r.y = blend(shadow_y[seg], shadow_y[seg+1], frac);
    r.z = blend(shadow_z[seg], shadow_z[seg+1], frac);
    return r;
  endfunction

  // Sends one request, waits for its handshake and updates the prediction.
  task automatic push_request(input logic act, input logic [KeyIdxW-1:0] slot,
                              input logic [TimeW-1:0] tv, input logic [CompW-1:0] cx,
                              input logic [CompW-1:0] cy, input logic [CompW-1:0] cz);
    int unsigned gap;
    if (send_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {2'b00, cz, cy, cx, tv, slot};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (act == ACT_WRITE) begin
      shadow_time[slot] = tv;
      shadow_x[slot]    = cx;
      shadow_y[slot]    = cy;
      shadow_z[slot]    = cz;
      writes_sent++;
    end else begin
      pending_vecs.push_back(lerp_at_time(tv));
      queries_sent++;
    end
  endtask

  // Query with random filler in the fields the block ignores.
  task automatic push_query(input logic [TimeW-1:0] tm);
    push_request(ACT_QUERY, KeyIdxW'($urandom), tm, $urandom, $urandom, $urandom);
  endtask

  // Stops the stream and waits until every result is in and the block is quiet.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_vecs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Writes the key count register while the block is idle.
  task automatic set_key_count(input logic [CountW-1:0] cnt);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cnt;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    shadow_count = cnt;
  endtask

  // Loads keys 0..n-1 with rising times; a broken load repeats or scrambles times.
  task automatic load_keys(input int unsigned n, input bit broken);
    logic [TimeW-1:0] stamp;
    int unsigned step_max;
    step_max = ($urandom_range(0, 2) == 0) ? 8 : (32'h8000_0000 / n);
    stamp    = $urandom_range(0, 32'h4000_0000);
    for (int unsigned s = 0; s < n; s++) begin
      push_request(ACT_WRITE, KeyIdxW'(s), stamp, $urandom, $urandom, $urandom);
      if (broken && $urandom_range(0, 3) == 0) begin
        stamp = $urandom;
      end else begin
        stamp = stamp + $urandom_range(broken ? 0 : 1, step_max);
      end
    end
  endtask

  // Query times on, next to, between and outside the loaded keys.
  function automatic logic [TimeW-1:0] pick_query_time(input int unsigned n);
    int unsigned k;
    logic [TimeW-1:0] lo;
    logic [TimeW-1:0] hi;
    k  = $urandom_range(0, n - 1);
    lo = shadow_time[k];
    hi = shadow_time[(k + 1 < n) ? k + 1 : k];
    case ($urandom_range(0, 9))
      0, 1, 2: return lo;
      3, 4, 5, 6: begin
        if (hi > lo) return lo + $urandom_range(0, hi - lo);
        return lo;
      end
      7: return lo - 1;
      8: return lo + 1;
      default: return $urandom;
    endcase
  endfunction

  // Compares one component of a result.
  task automatic check_comp(input string name, input logic [CompW-1:0] want,
                            input logic [CompW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      err_count++;
    end
  endtask

  // Result checker: each accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      rx_vec = m_axis_tdata;
      if (pending_vecs.size() == 0) begin
        $display("%0t: result with no query pending, expected none, actual x=%h y=%h z=%h",
                 $time, rx_vec.x, rx_vec.y, rx_vec.z);
        err_count++;
      end else begin
        want_vec = pending_vecs.pop_front();
        check_comp("out_x", want_vec.x, rx_vec.x);
        check_comp("out_y", want_vec.y, rx_vec.y);
        check_comp("out_z", want_vec.z, rx_vec.z);
        results_seen++;
      end
    end
  end

  // Receiver back-pressure in random bursts.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
      stall_left    <= $urandom_range(1, 10) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // A single key answers every query unchanged, also with a count of zero.
  task automatic test_single_key();
    push_request(ACT_WRITE, '0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    push_query(32'h0000_0000);
    push_query(32'hFFFF_FFFF);
    set_key_count(7'd0);
    push_query($urandom);
  endtask

  // Two keys spanning the full component range, queried at and around both ends.
  task automatic test_two_keys();
    set_key_count(7'd2);
    push_request(ACT_WRITE, 6'd0, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    push_request(ACT_WRITE, 6'd1, 32'h0003_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h5);
    push_query(32'h0000_0000);
    push_query(32'h0001_0000);
    push_query(32'h0001_0001);
    push_query(32'h0002_0000);
    push_query(32'h0002_FFFF);
    push_query(32'h0003_0000);
    push_query(32'hFFFF_FFFF);
  endtask

  // Equal and falling key times, where only the clamp rules apply.
  task automatic test_degenerate_keys();
    push_request(ACT_WRITE, 6'd1, 32'h0001_0000, $urandom, $urandom, $urandom);
    push_query(32'h0001_0000);
    push_query(32'h0000_FFFF);
    push_query(32'h0002_0000);
    push_request(ACT_WRITE, 6'd1, 32'h0000_0000, $urandom, $urandom, $urandom);
    push_query(32'h0000_8000);
  endtask

  // Every slot gets a key, so any count is safe from here on.
  task automatic test_table_fill();
    load_keys(MAX_KEYS, 1'b0);
  endtask

  // Counts above the table size saturate; the full table is searched.
  task automatic test_count_limits();
    set_key_count(7'd127);
    push_query(32'hFFFF_FFFF);
    push_query(pick_query_time(used_keys()));
    push_query(pick_query_time(used_keys()));
    set_key_count(7'd65);
    push_query(32'h0000_0000);
    push_query(pick_query_time(used_keys()));
    set_key_count(7'd64);
    push_query(pick_query_time(used_keys()));
    push_query(pick_query_time(used_keys()));
  endtask

  // Phases of one key count each: a key load, then queries with a few stray writes.
  task automatic test_random_phases();
    int unsigned n;
    int unsigned queries;
    bit broken;
    while (items_sent < RandomItems) begin
      case ($urandom_range(0, 9))
        0:       n = 1;
        1:       n = MAX_KEYS;
        2:       n = $urandom_range(9, MAX_KEYS - 1);
        default: n = $urandom_range(2, 8);
      endcase
      set_key_count(CountW'(n));
      broken = ($urandom_range(0, 4) == 0);
      load_keys(n, broken);
      queries = $urandom_range(10, 40);
      repeat (queries) begin
        if ($urandom_range(0, 9) == 0) begin
          push_request(ACT_WRITE, KeyIdxW'($urandom), $urandom, $urandom, $urandom, $urandom);
        end else begin
          push_query(pick_query_time(n));
        end
      end
    end
  endtask

  // The sender holds off until every result is back, several times over.
  task automatic test_pressure();
    set_key_count(7'd5);
    repeat (5) begin
      repeat (4) push_query(pick_query_time(used_keys()));
      wait_idle();
    end
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_streaming_tail();
    send_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    set_key_count(7'd3);
    load_keys(3, 1'b0);
    repeat (TailItems) push_query(pick_query_time(used_keys()));
  endtask

  // Test sequence.
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_key();
    test_two_keys();
    test_degenerate_keys();
    test_table_fill();
    test_count_limits();
    test_random_phases();
    test_pressure();
    test_streaming_tail();
    wait_idle();
    repeat (TailCycles) @(posedge clk_i);
    $display("Covered %0d requests: %0d queries and %0d key writes, %0d results checked.",
             items_sent, queries_sent, writes_sent, results_seen);
    $display("Key counts 0, 1 to 64, 65 and 127 were used, with and without idle bursts.");
    if (err_count == 0) begin
      $display("keyframe_vector_lerp verification clean");
    end else begin
      $display("keyframe_vector_lerp verification failed");
    end
    $finish;
  end

endmodule
